// File: rtl/bfgl_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap font glyph layout: shared package
// Types, constants and helpers used by the layout front end, the back end
// and the top level.
// ----------------------------------------------------------------------------
package bfgl_pkg;

   // Number of entries in the glyph width table.
   localparam int GLYPH_COUNT = 256;
   localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
   localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [15:0] LINE_HEIGHT  = 16'd20;
   localparam logic [15:0] UV_INSET     = 16'd8;
   localparam int          FRAC_BITS    = 4;

   // Configuration register indexes.
   localparam logic [2:0] REG_ORIGIN_X        = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y        = 3'd1;
   localparam logic [2:0] REG_CELL_WIDTH      = 3'd2;
   localparam logic [2:0] REG_CELL_HEIGHT     = 3'd3;
   localparam logic [2:0] REG_LETTERS_PER_ROW = 3'd4;
   localparam logic [2:0] REG_FIRST_CODE      = 3'd5;

   // Item kinds after classification.
   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_NEWLINE = 2'd1;
   localparam logic [1:0] KIND_GLYPH   = 2'd2;

   typedef struct packed {
      logic [11:0] origin_x;
      logic [11:0] origin_y;
      logic [7:0]  cell_width;
      logic [7:0]  cell_height;
      logic [7:0]  letters_per_row;
      logic [7:0]  first_code;
   } cfg_type;

   // A classified item: code holds the table index for a load and the
   // glyph number for a glyph.
   typedef struct packed {
      logic [1:0] kind;
      logic       first;
      logic [7:0] code;
      logic [7:0] width_value;
   } item_type;

   typedef struct packed {
      logic [15:0] tex_u0;
      logic [15:0] tex_v0;
      logic [15:0] tex_u1;
      logic [15:0] tex_v1;
      logic [15:0] quad_left;
      logic [15:0] quad_right;
      logic [15:0] quad_top;
      logic [15:0] quad_bottom;
   } quad_type;

   function automatic logic [15:0] sat16(input logic [23:0] value);
      logic [15:0] result;
      if (value[23:16] != 8'd0) begin
         result = 16'hFFFF;
      end else begin
         result = value[15:0];
      end
      return result;
   endfunction

endpackage

// File: rtl/bfgl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfgl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bfgl_front.sv
// ----------------------------------------------------------------------------
// Bitmap font glyph layout: front end
// Accepts request transactions, sorts them into loads, newlines and glyphs,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bfgl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_command,
   input  logic                 req_first_of_text,
   input  logic [7:0]           req_char_code,
   input  logic [7:0]           req_width_value,
   input  logic [7:0]           first_code,
   output logic                 item_valid,
   output bfgl_pkg::item_type   item,
   input  logic                 item_pop
);

   bfgl_pkg::item_type q_ff [2];
   bfgl_pkg::item_type new_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok, pop_ok;

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;

   always_comb begin
      new_item.first       = req_first_of_text;
      new_item.width_value = req_width_value;
      if (!req_command) begin
         new_item.kind = bfgl_pkg::KIND_LOAD;
         new_item.code = req_char_code;
      end else if (req_char_code == bfgl_pkg::NEWLINE_CODE) begin
         new_item.kind = bfgl_pkg::KIND_NEWLINE;
         new_item.code = req_char_code;
      end else begin
         // The glyph number wraps modulo 256.
         new_item.kind = bfgl_pkg::KIND_GLYPH;
         new_item.code = req_char_code - first_code;
      end
   end

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: rtl/bfgl_back.sv
// ----------------------------------------------------------------------------
// Bitmap font glyph layout: back end
// Carries out queued items: writes the width table, moves the pen, divides
// the glyph number into an atlas tile, builds the quad and queues it.
// ----------------------------------------------------------------------------
module bfgl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bfgl_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  bfgl_pkg::item_type   item,
   output logic                 item_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output bfgl_pkg::quad_type   rsp_quad
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  quo_ff, quo_in;
   logic        glyph_ok_ff, glyph_ok_in;
   logic [15:0] uprod_ff, uprod_in;
   logic [15:0] vprod_ff, vprod_in;
   logic [7:0]  width_ff, width_in;
   logic [15:0] pen_ff, pen_in;
   logic [15:0] line_ff, line_in;

   bfgl_pkg::quad_type oq_ff [2];
   logic       oq_wr_ff, oq_wr_in;
   logic       oq_rd_ff, oq_rd_in;
   logic [1:0] oq_cnt_ff, oq_cnt_in;
   logic       oq_push, oq_pop;

   logic                             ram_wr_en;
   logic                             ram_rd_en;
   logic [7:0]                       ram_rd_data;
   logic [bfgl_pkg::GLYPH_IDX_W-1:0] ram_addr;

   logic [7:0]  lpr_eff;
   logic [8:0]  rem_sh;
   logic        rem_ge;
   logic [15:0] base_pen;
   logic [15:0] base_line;
   logic [23:0] u0_full, v0_full, u1_full, v1_full, top_full, bottom_full;
   bfgl_pkg::quad_type quad;

   assign ram_addr = item.code[bfgl_pkg::GLYPH_IDX_W-1:0];

   bfgl_ram #(
      .WIDTH (8),
      .DEPTH (bfgl_pkg::GLYPH_COUNT)
   ) u_width_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (item.width_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // A zero letters-per-row setting behaves as one.
   assign lpr_eff = (cfg.letters_per_row == 8'd0) ? 8'd1 : cfg.letters_per_row;
   assign rem_sh  = {rem_ff, quo_ff[7]};
   assign rem_ge  = (rem_sh >= {1'b0, lpr_eff});

   assign base_pen  = item.first ? {4'd0, cfg.origin_x} : pen_ff;
   assign base_line = item.first ? 16'd0 : line_ff;

   // Quad assembly, all sums at full width before saturation.
   always_comb begin
      u0_full     = 24'(uprod_ff) << bfgl_pkg::FRAC_BITS;
      v0_full     = (24'(vprod_ff) << bfgl_pkg::FRAC_BITS) + 24'(bfgl_pkg::UV_INSET);
      u1_full     = u0_full + (24'(width_ff) << bfgl_pkg::FRAC_BITS);
      v1_full     = v0_full + (24'(cfg.cell_height) << bfgl_pkg::FRAC_BITS)
                    - 24'(bfgl_pkg::UV_INSET);
      top_full    = 24'(cfg.origin_y) + 24'(line_ff);
      bottom_full = top_full + 24'(bfgl_pkg::LINE_HEIGHT);

      quad.tex_u0      = bfgl_pkg::sat16(u0_full);
      quad.tex_v0      = bfgl_pkg::sat16(v0_full);
      quad.tex_u1      = bfgl_pkg::sat16(u1_full);
      quad.tex_v1      = bfgl_pkg::sat16(v1_full);
      quad.quad_left   = pen_ff;
      quad.quad_right  = bfgl_pkg::sat16(24'(pen_ff) + 24'(width_ff));
      quad.quad_top    = bfgl_pkg::sat16(top_full);
      quad.quad_bottom = bfgl_pkg::sat16(bottom_full);
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      glyph_ok_in = glyph_ok_ff;
      uprod_in    = uprod_ff;
      vprod_in    = vprod_ff;
      width_in    = width_ff;
      pen_in      = pen_ff;
      line_in     = line_ff;
      item_pop    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      oq_push     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               case (item.kind)
                  bfgl_pkg::KIND_LOAD: begin
                     ram_wr_en = ({1'b0, item.code} < bfgl_pkg::GLYPH_LIMIT);
                  end
                  bfgl_pkg::KIND_NEWLINE: begin
                     pen_in  = {4'd0, cfg.origin_x};
                     line_in = bfgl_pkg::sat16(24'(base_line) + 24'(bfgl_pkg::LINE_HEIGHT));
                  end
                  default: begin
                     // Start the divide and fetch the glyph width together.
                     pen_in      = base_pen;
                     line_in     = base_line;
                     glyph_ok_in = ({1'b0, item.code} < bfgl_pkg::GLYPH_LIMIT);
                     ram_rd_en   = 1'b1;
                     rem_in      = 8'd0;
                     quo_in      = item.code;
                     cnt_in      = 3'd0;
                     state_in    = ST_DIV;
                  end
               endcase
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            rem_in = rem_ge ? 8'(rem_sh - {1'b0, lpr_eff}) : rem_sh[7:0];
            quo_in = {quo_ff[6:0], rem_ge};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            uprod_in = 16'(rem_ff) * 16'(cfg.cell_width);
            vprod_in = 16'(quo_ff) * 16'(cfg.cell_height);
            width_in = glyph_ok_ff ? ram_rd_data : 8'd0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (oq_cnt_ff != 2'd2) begin
               oq_push  = 1'b1;
               pen_in   = quad.quad_right;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result queue.
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp_quad  = oq_ff[oq_rd_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      oq_wr_in  = oq_push ? !oq_wr_ff : oq_wr_ff;
      oq_rd_in  = oq_pop ? !oq_rd_ff : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + 2'(oq_push) - 2'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pen_ff    <= 16'd0;
         line_ff   <= 16'd0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         pen_ff    <= pen_in;
         line_ff   <= line_in;
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      glyph_ok_ff <= glyph_ok_in;
      uprod_ff    <= uprod_in;
      vprod_ff    <= vprod_in;
      width_ff    <= width_in;
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= quad;
      end
   end

endmodule

// File: rtl/bitmap_font_glyph_layout.sv
// ----------------------------------------------------------------------------
// Bitmap font glyph layout: top level
// Turns a stream of characters into textured screen quads from a font atlas.
// ----------------------------------------------------------------------------
// A width-table load or a newline is carried out in the back end's idle state; a
// printable character goes through a start step, the bit-serial divide of the
// glyph number by the letters per row, the tile multiplies and the quad write, so
// the divider loop sets the character rate while the result queue has room. The
// back end takes the next item only once the last one is done. Requests queue two
// deep ahead of the back end and results two deep behind it, so each side may stall
// without holding up the other. The glyph width table has no reset: lay out a
// character only after its width entry has been loaded. Registers should be changed
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_layout (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_push,
   output logic        req_full,
   input  logic        req_command,
   input  logic        req_first_of_text,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_width_value,

   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_tex_u0,
   output logic [15:0] rsp_tex_v0,
   output logic [15:0] rsp_tex_u1,
   output logic [15:0] rsp_tex_v1,
   output logic [15:0] rsp_quad_left,
   output logic [15:0] rsp_quad_right,
   output logic [15:0] rsp_quad_top,
   output logic [15:0] rsp_quad_bottom,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bfgl_pkg::cfg_type  cfg_ff, cfg_in;
   bfgl_pkg::item_type item;
   bfgl_pkg::quad_type quad;
   logic               item_valid;
   logic               item_pop;
   logic               csr_write;
   logic [2:0]         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            bfgl_pkg::REG_ORIGIN_X:        cfg_in.origin_x        = csr_pwdata[11:0];
            bfgl_pkg::REG_ORIGIN_Y:        cfg_in.origin_y        = csr_pwdata[11:0];
            bfgl_pkg::REG_CELL_WIDTH:      cfg_in.cell_width      = csr_pwdata[7:0];
            bfgl_pkg::REG_CELL_HEIGHT:     cfg_in.cell_height     = csr_pwdata[7:0];
            bfgl_pkg::REG_LETTERS_PER_ROW: cfg_in.letters_per_row = csr_pwdata[7:0];
            bfgl_pkg::REG_FIRST_CODE:      cfg_in.first_code      = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bfgl_pkg::REG_ORIGIN_X:        csr_prdata = 32'(cfg_ff.origin_x);
         bfgl_pkg::REG_ORIGIN_Y:        csr_prdata = 32'(cfg_ff.origin_y);
         bfgl_pkg::REG_CELL_WIDTH:      csr_prdata = 32'(cfg_ff.cell_width);
         bfgl_pkg::REG_CELL_HEIGHT:     csr_prdata = 32'(cfg_ff.cell_height);
         bfgl_pkg::REG_LETTERS_PER_ROW: csr_prdata = 32'(cfg_ff.letters_per_row);
         bfgl_pkg::REG_FIRST_CODE:      csr_prdata = 32'(cfg_ff.first_code);
         default:                       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x        <= 12'd0;
         cfg_ff.origin_y        <= 12'd0;
         cfg_ff.cell_width      <= 8'd16;
         cfg_ff.cell_height     <= 8'd16;
         cfg_ff.letters_per_row <= 8'd16;
         cfg_ff.first_code      <= 8'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bfgl_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_command       (req_command),
      .req_first_of_text (req_first_of_text),
      .req_char_code     (req_char_code),
      .req_width_value   (req_width_value),
      .first_code        (cfg_ff.first_code),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop)
   );

   bfgl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_quad   (quad)
   );

   assign rsp_tex_u0      = quad.tex_u0;
   assign rsp_tex_v0      = quad.tex_v0;
   assign rsp_tex_u1      = quad.tex_u1;
   assign rsp_tex_v1      = quad.tex_v1;
   assign rsp_quad_left   = quad.quad_left;
   assign rsp_quad_right  = quad.quad_right;
   assign rsp_quad_top    = quad.quad_top;
   assign rsp_quad_bottom = quad.quad_bottom;

endmodule

// File: tb/bitmap_font_glyph_layout_tb.sv
// ----------------------------------------------------------------------------
// Bitmap font glyph layout: testbench
// Sends width-table loads, characters and newlines through the request queue,
// works out each quad with a behavioural copy of the layout rules or takes it
// from the script, and checks the result queue field by field under several
// register settings, including pen saturation.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_layout_tb;

   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int REPORT_LIMIT    = 10;

   localparam bit CMD_LOAD   = 1'b0;
   localparam bit CMD_LAYOUT = 1'b1;

   localparam bfgl_pkg::cfg_type RESET_CFG = '{origin_x: 12'd0, origin_y: 12'd0,
                                               cell_width: 8'd16, cell_height: 8'd16,
                                               letters_per_row: 8'd16, first_code: 8'd32};

   typedef struct {
      bit                 command;
      bit                 first;
      logic [7:0]         code;
      logic [7:0]         wval;
      bit                 typed;
      bfgl_pkg::quad_type quad;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_command = 1'b0;
   logic        req_first_of_text = 1'b0;
   logic [7:0]  req_char_code = 8'd0;
   logic [7:0]  req_width_value = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [15:0] rsp_tex_u0, rsp_tex_v0, rsp_tex_u1, rsp_tex_v1;
   logic [15:0] rsp_quad_left, rsp_quad_right, rsp_quad_top, rsp_quad_bottom;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = 5'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Behavioural copy of the block's state and registers.
   bfgl_pkg::cfg_type layout_cfg;
   logic [15:0]       pen_x_model;
   logic [15:0]       line_off_model;
   logic [7:0]        glyph_width_tab [256];
   bit                width_loaded [256];

   bfgl_pkg::quad_type quads_due [$];
   script_row_type     script [$];
   bfgl_pkg::quad_type seen_quad;
   bfgl_pkg::quad_type want_quad;

   int errors        = 0;
   int items_sent    = 0;
   int quads_checked = 0;
   int stall_cycles  = 0;
   int tx_idle_pct   = 35;
   int rx_stall_pct  = 53;

   bitmap_font_glyph_layout DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] clip16(input int unsigned value);
      return (value > 32'd65535) ? 16'hFFFF : 16'(value);
   endfunction

   // Applies one accepted item to the model state; returns 1 when it yields a quad.
   function automatic bit place_glyph(input bit command, input bit first,
                                      input logic [7:0] code, input logic [7:0] wval,
                                      output bfgl_pkg::quad_type q);
      logic [7:0]  glyph;
      int unsigned wid, lpr, tx, ty, u0, v0, u1, v1, top;
      q = '0;
      if (command == CMD_LOAD) begin
         glyph_width_tab[code] = wval;
         width_loaded[code] = 1'b1;
         return 1'b0;
      end
      if (first) begin
         pen_x_model = {4'd0, layout_cfg.origin_x};
         line_off_model = '0;
      end
      if (code == bfgl_pkg::NEWLINE_CODE) begin
         pen_x_model = {4'd0, layout_cfg.origin_x};
         line_off_model = clip16(32'(line_off_model) + 32'(bfgl_pkg::LINE_HEIGHT));
         return 1'b0;
      end
      glyph = code - layout_cfg.first_code;
      wid = 32'(glyph_width_tab[glyph]);
      lpr = (layout_cfg.letters_per_row == 8'd0) ? 32'd1 : 32'(layout_cfg.letters_per_row);
      tx = 32'(glyph) % lpr;
      ty = 32'(glyph) / lpr;
      u0 = (tx * 32'(layout_cfg.cell_width)) << bfgl_pkg::FRAC_BITS;
      v0 = ((ty * 32'(layout_cfg.cell_height)) << bfgl_pkg::FRAC_BITS)
           + 32'(bfgl_pkg::UV_INSET);
      u1 = u0 + (wid << bfgl_pkg::FRAC_BITS);
      v1 = v0 + (32'(layout_cfg.cell_height) << bfgl_pkg::FRAC_BITS)
           - 32'(bfgl_pkg::UV_INSET);
      top = 32'(layout_cfg.origin_y) + 32'(line_off_model);
      q.tex_u0      = clip16(u0);
      q.tex_v0      = clip16(v0);
      q.tex_u1      = clip16(u1);
      q.tex_v1      = clip16(v1);
      q.quad_left   = pen_x_model;
      q.quad_right  = clip16(32'(pen_x_model) + wid);
      q.quad_top    = clip16(top);
      q.quad_bottom = clip16(top + 32'(bfgl_pkg::LINE_HEIGHT));
      pen_x_model = q.quad_right;
      return 1'b1;
   endfunction

   function automatic script_row_type make_row(input bit command, input bit first,
                                               input logic [7:0] code, input logic [7:0] wval,
                                               input bit typed,
                                               input bfgl_pkg::quad_type quad);
      script_row_type row;
      row.command = command;
      row.first   = first;
      row.code    = code;
      row.wval    = wval;
      row.typed   = typed;
      row.quad    = quad;
      return row;
   endfunction

   function automatic logic [11:0] reg_field(input bfgl_pkg::cfg_type c, input int idx);
      case (idx)
         bfgl_pkg::REG_ORIGIN_X:        return c.origin_x;
         bfgl_pkg::REG_ORIGIN_Y:        return c.origin_y;
         bfgl_pkg::REG_CELL_WIDTH:      return {4'd0, c.cell_width};
         bfgl_pkg::REG_CELL_HEIGHT:     return {4'd0, c.cell_height};
         bfgl_pkg::REG_LETTERS_PER_ROW: return {4'd0, c.letters_per_row};
         bfgl_pkg::REG_FIRST_CODE:      return {4'd0, c.first_code};
         default:                       return '0;
      endcase
   endfunction

   // Leans towards the ends of the byte range now and then.
   function automatic logic [7:0] biased_byte();
      if ($urandom_range(7) == 0) begin
         return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
      end
      return 8'($urandom);
   endfunction

   function automatic bfgl_pkg::cfg_type phase_cfg(input int phase);
      bfgl_pkg::cfg_type c;
      c.origin_x        = 12'($urandom_range(4095));
      c.origin_y        = 12'($urandom_range(4095));
      c.cell_width      = 8'($urandom_range(1, 255));
      c.cell_height     = 8'($urandom_range(1, 255));
      c.letters_per_row = 8'($urandom_range(1, 255));
      c.first_code      = 8'($urandom);
      case (phase)
         1: c = '{12'd0, 12'd0, 8'd1, 8'd1, 8'd1, 8'd0};
         2: c = '{12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 8'd255};
         // A zero letters-per-row setting behaves as a single column.
         4: c = '{12'd4095, 12'd0, 8'd255, 8'd1, 8'd0, bfgl_pkg::NEWLINE_CODE};
         7: c = '{12'd123, 12'd2000, 8'd8, 8'd12, 8'd32, 8'd32};
         default: ;
      endcase
      return c;
   endfunction

   // All driver tasks start and finish just after a falling edge.
   task automatic send_item(input bit command, input bit first, input logic [7:0] code,
                            input logic [7:0] wval, input bit typed,
                            input bfgl_pkg::quad_type typed_quad);
      bfgl_pkg::quad_type q;
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push          <= 1'b1;
      req_command       <= command;
      req_first_of_text <= first;
      req_char_code     <= code;
      req_width_value   <= wval;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      if (place_glyph(command, first, code, wval, q)) begin
         quads_due.push_back(typed ? typed_quad : q);
      end
      items_sent++;
   endtask

   task automatic csr_access(input bit write, input int idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {3'(idx), 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_registers(input bfgl_pkg::cfg_type c);
      logic [31:0] rdata;
      for (int idx = int'(bfgl_pkg::REG_ORIGIN_X); idx <= int'(bfgl_pkg::REG_FIRST_CODE);
           idx++) begin
         csr_access(1'b0, idx, 32'd0, rdata);
         if (rdata !== {20'd0, reg_field(c, idx)}) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("register %0d read back: expected %0d actual %0d",
                        idx, reg_field(c, idx), rdata);
         end
      end
   endtask

   // Upper data bits carry noise; the block is expected to keep only the field.
   task automatic program_layout(input bfgl_pkg::cfg_type c);
      logic [31:0] data;
      logic [31:0] unused;
      logic [11:0] field;
      for (int idx = int'(bfgl_pkg::REG_ORIGIN_X); idx <= int'(bfgl_pkg::REG_FIRST_CODE);
           idx++) begin
         data = $urandom;
         field = reg_field(c, idx);
         if (idx == int'(bfgl_pkg::REG_ORIGIN_X) || idx == int'(bfgl_pkg::REG_ORIGIN_Y))
            data = {data[31:12], field};
         else
            data = {data[31:8], field[7:0]};
         csr_access(1'b1, idx, data, unused);
      end
      layout_cfg = c;
      check_registers(c);
   endtask

   // Texts of random content, mostly opened with a first-of-text flag, with stray
   // loads and misplaced flags mixed in.
   task automatic run_text_stream(input int quota);
      int         sent;
      int         len;
      int         pick;
      bit         first;
      logic [7:0] glyph;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(99) < 8) begin
            send_item(CMD_LOAD, 1'($urandom), 8'($urandom), biased_byte(), 1'b0, '0);
            sent++;
         end else begin
            len = $urandom_range(1, 14);
            for (int k = 0; k < len; k++) begin
               first = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
               pick = $urandom_range(99);
               if (pick < 12) begin
                  send_item(CMD_LAYOUT, first, bfgl_pkg::NEWLINE_CODE, 8'($urandom),
                            1'b0, '0);
               end else if (pick < 20) begin
                  send_item(CMD_LOAD, first, 8'($urandom), biased_byte(), 1'b0, '0);
               end else begin
                  glyph = biased_byte();
                  // A glyph is laid out only once its width entry holds a value.
                  if (!width_loaded[glyph]) begin
                     send_item(CMD_LOAD, 1'($urandom), glyph, biased_byte(), 1'b0, '0);
                     sent++;
                  end
                  send_item(CMD_LAYOUT, first, 8'(glyph + layout_cfg.first_code),
                            8'($urandom), 1'b0, '0);
               end
               sent++;
            end
         end
      end
   endtask

   // Drives the pen or the line offset into saturation with the widest glyph.
   task automatic run_saturation(input int newlines, input int glyphs);
      logic [7:0] glyph;
      glyph = 8'd7;
      if (8'(glyph + layout_cfg.first_code) == bfgl_pkg::NEWLINE_CODE) glyph = 8'd8;
      send_item(CMD_LOAD, 1'b0, glyph, 8'hFF, 1'b0, '0);
      for (int k = 0; k < newlines; k++)
         send_item(CMD_LAYOUT, k == 0, bfgl_pkg::NEWLINE_CODE, 8'($urandom), 1'b0, '0);
      for (int k = 0; k < glyphs; k++)
         send_item(CMD_LAYOUT, newlines == 0 && k == 0, 8'(glyph + layout_cfg.first_code),
                   8'($urandom), 1'b0, '0);
   endtask

   // Loads and newlines leave no trace in the result queue, so an extra settling
   // wait lets the back end finish before the registers are touched.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (quads_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_pop <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         seen_quad = {rsp_tex_u0, rsp_tex_v0, rsp_tex_u1, rsp_tex_v1,
                      rsp_quad_left, rsp_quad_right, rsp_quad_top, rsp_quad_bottom};
         if (quads_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected quad transaction: %h", seen_quad);
         end else begin
            want_quad = quads_due.pop_front();
            quads_checked++;
            if (seen_quad.tex_u0 !== want_quad.tex_u0 || seen_quad.tex_v0 !== want_quad.tex_v0 ||
                seen_quad.tex_u1 !== want_quad.tex_u1 || seen_quad.tex_v1 !== want_quad.tex_v1 ||
                seen_quad.quad_left !== want_quad.quad_left ||
                seen_quad.quad_right !== want_quad.quad_right ||
                seen_quad.quad_top !== want_quad.quad_top ||
                seen_quad.quad_bottom !== want_quad.quad_bottom) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("quad %0d expected: u0=%0d v0=%0d u1=%0d v1=%0d l=%0d r=%0d t=%0d b=%0d",
                           quads_checked, want_quad.tex_u0, want_quad.tex_v0, want_quad.tex_u1,
                           want_quad.tex_v1, want_quad.quad_left, want_quad.quad_right,
                           want_quad.quad_top, want_quad.quad_bottom);
                  $display("quad %0d actual:   u0=%0d v0=%0d u1=%0d v1=%0d l=%0d r=%0d t=%0d b=%0d",
                           quads_checked, seen_quad.tex_u0, seen_quad.tex_v0, seen_quad.tex_u1,
                           seen_quad.tex_v1, seen_quad.quad_left, seen_quad.quad_right,
                           seen_quad.quad_top, seen_quad.quad_bottom);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d quads outstanding",
                  stall_cycles, quads_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      layout_cfg = RESET_CFG;
      pen_x_model = '0;
      line_off_model = '0;
      for (int i = 0; i < 256; i++) begin
         glyph_width_tab[i] = '0;
         width_loaded[i] = 1'b0;
      end

      // Rows under the reset settings: origin 0, 16x16 cells, 16 per row, first code 32.
      script.push_back(make_row(CMD_LOAD,   1'b0, 8'd0,   8'd8,   1'b0, '0));
      script.push_back(make_row(CMD_LOAD,   1'b0, 8'd255, 8'd255, 1'b0, '0));
      script.push_back(make_row(CMD_LOAD,   1'b1, 8'd1,   8'd0,   1'b0, '0));
      script.push_back(make_row(CMD_LOAD,   1'b0, 8'd95,  8'd1,   1'b0, '0));
      script.push_back(make_row(CMD_LAYOUT, 1'b1, 8'd32,  8'hAA,  1'b1,
         {16'd0, 16'd8, 16'd128, 16'd256, 16'd0, 16'd8, 16'd0, 16'd20}));
      // The code just below the first code wraps round to the last glyph.
      script.push_back(make_row(CMD_LAYOUT, 1'b0, 8'd31,  8'h55,  1'b1,
         {16'd3840, 16'd3848, 16'd7920, 16'd4096, 16'd8, 16'd263, 16'd0, 16'd20}));
      script.push_back(make_row(CMD_LAYOUT, 1'b0, 8'd33,  8'hFF,  1'b1,
         {16'd256, 16'd8, 16'd256, 16'd256, 16'd263, 16'd263, 16'd0, 16'd20}));
      script.push_back(make_row(CMD_LAYOUT, 1'b0, bfgl_pkg::NEWLINE_CODE, 8'hFF, 1'b0, '0));
      script.push_back(make_row(CMD_LAYOUT, 1'b0, 8'd127, 8'd0,   1'b1,
         {16'd3840, 16'd1288, 16'd3856, 16'd1536, 16'd0, 16'd1, 16'd20, 16'd40}));
      script.push_back(make_row(CMD_LAYOUT, 1'b1, bfgl_pkg::NEWLINE_CODE, 8'd0, 1'b0, '0));
      script.push_back(make_row(CMD_LAYOUT, 1'b0, 8'd32,  8'd0,   1'b1,
         {16'd0, 16'd8, 16'd128, 16'd256, 16'd0, 16'd8, 16'd20, 16'd40}));
      // The newline code used as a table index is an ordinary load.
      script.push_back(make_row(CMD_LOAD,   1'b0, bfgl_pkg::NEWLINE_CODE, 8'd77, 1'b0, '0));
      script.push_back(make_row(CMD_LAYOUT, 1'b1, 8'd42,  8'd0,   1'b1,
         {16'd2560, 16'd8, 16'd3792, 16'd256, 16'd0, 16'd77, 16'd0, 16'd20}));
      script.push_back(make_row(CMD_LOAD,   1'b1, 8'd0,   8'd255, 1'b0, '0));
      script.push_back(make_row(CMD_LAYOUT, 1'b0, 8'd32,  8'd0,   1'b1,
         {16'd0, 16'd8, 16'd4080, 16'd256, 16'd77, 16'd332, 16'd0, 16'd20}));
      script.push_back(make_row(CMD_LOAD,   1'b0, 8'd223, 8'd200, 1'b0, '0));
      script.push_back(make_row(CMD_LAYOUT, 1'b0, 8'd255, 8'h0F,  1'b0, '0));
      script.push_back(make_row(CMD_LOAD,   1'b0, 8'd224, 8'd3,   1'b0, '0));
      script.push_back(make_row(CMD_LAYOUT, 1'b1, 8'd0,   8'hF0,  1'b0, '0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      check_registers(RESET_CFG);

      foreach (script[i])
         send_item(script[i].command, script[i].first, script[i].code, script[i].wval,
                   script[i].typed, script[i].quad);
      run_text_stream(ITEMS_PER_PHASE - script.size());
      wait_idle();

      for (int phase = 1; phase < PHASES; phase++) begin
         if (phase >= 6) begin
            tx_idle_pct = 0;
            rx_stall_pct = 0;
         end else if (phase >= 3) begin
            tx_idle_pct = 53;
            rx_stall_pct = 35;
         end
         program_layout(phase_cfg(phase));
         run_text_stream(ITEMS_PER_PHASE);
         if (phase == 2) run_saturation(0, 260);
         wait_idle();
      end

      $display("%0d items sent under %0d register settings, %0d quads checked, %0d errors",
               items_sent, PHASES, quads_checked, errors);
      $display("covered width loads, newlines, pen and texture saturation, a zero row count");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
